// ===== sv/bd_pkg.sv =====
`default_nettype none

package bd_pkg;

    localparam int DEPTH_DEF = 16;

    localparam int VALUE_W  = 32;
    localparam int REQ_W    = 3;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 4;
    localparam int COUNT_W  = 5;

    localparam logic [REQ_W-1:0] REQ_INS_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_INS_BACK  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_DEL_FRONT = 3'd2;
    localparam logic [REQ_W-1:0] REQ_DEL_BACK  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_SEARCH    = 3'd4;

    localparam logic [STATUS_W-1:0] STS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STS_EMPTY = 2'd2;

    // what a cell latches in a cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_FROM_PREV,
        CELL_FROM_NEXT
    } t_cell_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } t_state;

endpackage

`default_nettype wire

// ===== sv/bd_req_if.sv =====
`default_nettype none

interface bd_req_if
    import bd_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic        [REQ_W-1:0]   req_type;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink   (input valid, input req_type, input value, output ready);
endinterface

`default_nettype wire

// ===== sv/bd_rsp_if.sv =====
`default_nettype none

interface bd_rsp_if
    import bd_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [POS_W-1:0]    position;
    logic [COUNT_W-1:0]  count;

    modport source (output valid, output status, output found, output position,
                    output count, input ready);
    modport sink   (input valid, input status, input found, input position,
                    input count, output ready);
endinterface

`default_nettype wire

// ===== sv/bd_cell.sv =====
`default_nettype none

module bd_cell
    import bd_pkg::*;
(
    input  wire logic                i_clk,
    input  wire t_cell_op            i_op,
    input  wire logic [VALUE_W-1:0]  i_load_value,
    input  wire logic [VALUE_W-1:0]  i_prev_value,
    input  wire logic [VALUE_W-1:0]  i_next_value,
    output logic      [VALUE_W-1:0]  o_value
);

    logic [VALUE_W-1:0] r_value;
    logic [VALUE_W-1:0] n_value;

    always_comb begin
        unique case (i_op)
            CELL_HOLD:      n_value = r_value;
            CELL_LOAD:      n_value = i_load_value;
            CELL_FROM_PREV: n_value = i_prev_value;
            CELL_FROM_NEXT: n_value = i_next_value;
            default:        n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

`default_nettype wire

// ===== sv/bounded_deque_with_search_unit.sv =====
// Bounded double-ended queue with linear search.
//
// i_req (sink): req_type and value. 0/1 insert at front/back, 2/3 remove
// from front/back, 4 search for the first entry equal to value.
// o_rsp (source): status, found, position (from the front) and count after
// the request. Exactly one response per transfer, in request order.
//
// Entries live in a row of DEPTH cells, cell 0 being the front. Insert
// front and remove front shift the whole row by one cell, all cells together.
// Queue requests take one cycle: the response is valid the cycle after the
// transfer and a new request may be taken every cycle.
// A search rotates the row once around, one cell per cycle, comparing at
// cell 0: it steps through the scan state, then the finish state loads its
// response once the output register is free, and only then is a new request taken.
//
// Reset (synchronous, active low) empties the queue and drops any pending
// response. If the receiver stalls, the response is held in the output
// register and no new request is taken until it is transferred or taken
// in the same cycle.
`default_nettype none

module bounded_deque_with_search_unit
    import bd_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    bd_req_if.sink    i_req,
    bd_rsp_if.source  o_rsp
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_state             r_state;
    t_state             n_state;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic [IW-1:0]      r_step;
    logic [IW-1:0]      r_pos;
    logic               r_hit;
    logic [VALUE_W-1:0] r_key;

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic                r_out_found;
    logic [POS_W-1:0]    r_out_pos;
    logic [COUNT_W-1:0]  r_out_count;

    logic [VALUE_W-1:0] w_cell_value [DEPTH];
    t_cell_op           w_cell_op    [DEPTH];

    logic w_out_free;
    logic w_ready;
    logic w_accept;
    logic w_scan;
    logic w_fin_load;
    logic w_last_step;
    logic w_full;
    logic w_empty;
    logic w_do_ins_front;
    logic w_do_ins_back;
    logic w_do_del_front;

    logic [STATUS_W-1:0] w_status;
    logic [IW+POS_W-1:0] w_pos_ext;
    logic [CW+COUNT_W-1:0] w_cnt_ext;
    logic [CW+COUNT_W-1:0] w_ncnt_ext;

    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && w_ready;
    assign w_full      = (r_count == CW'(DEPTH));
    assign w_empty     = (r_count == '0);
    assign w_last_step = (r_step == IW'(DEPTH - 1));

    assign w_do_ins_front = w_accept && (i_req.req_type == REQ_INS_FRONT) && !w_full;
    assign w_do_ins_back  = w_accept && (i_req.req_type == REQ_INS_BACK) && !w_full;
    assign w_do_del_front = w_accept && (i_req.req_type == REQ_DEL_FRONT) && !w_empty;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_accept && (i_req.req_type == REQ_SEARCH)) n_state = ST_SCAN;
            ST_SCAN: if (w_last_step) n_state = ST_FIN;
            ST_FIN:  if (w_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        w_ready    = 1'b0;
        w_scan     = 1'b0;
        w_fin_load = 1'b0;
        unique case (r_state)
            ST_IDLE: w_ready    = w_out_free;
            ST_SCAN: w_scan     = 1'b1;
            ST_FIN:  w_fin_load = w_out_free;
            default: w_ready    = 1'b0;
        endcase
    end

    assign i_req.ready = w_ready;

    // queue request result
    always_comb begin
        n_count  = r_count;
        w_status = STS_DONE;
        unique case (i_req.req_type)
            REQ_INS_FRONT, REQ_INS_BACK: begin
                if (w_full) w_status = STS_FULL;
                else        n_count  = r_count + 1'b1;
            end
            REQ_DEL_FRONT, REQ_DEL_BACK: begin
                if (w_empty) w_status = STS_EMPTY;
                else         n_count  = r_count - 1'b1;
            end
            default: n_count = r_count;
        endcase
    end

    // cell row: prev/next wrap around to close the ring
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        always_comb begin
            priority if (w_scan || w_do_del_front) begin
                w_cell_op[gi] = CELL_FROM_NEXT;
            end else if (w_do_ins_front) begin
                w_cell_op[gi] = (gi == 0) ? CELL_LOAD : CELL_FROM_PREV;
            end else if (w_do_ins_back && (r_count == CW'(gi))) begin
                w_cell_op[gi] = CELL_LOAD;
            end else begin
                w_cell_op[gi] = CELL_HOLD;
            end
        end

        bd_cell u_cell (
            .i_clk        (i_clk),
            .i_op         (w_cell_op[gi]),
            .i_load_value (i_req.value),
            .i_prev_value (w_cell_value[(gi + DEPTH - 1) % DEPTH]),
            .i_next_value (w_cell_value[(gi + 1) % DEPTH]),
            .o_value      (w_cell_value[gi])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_step  <= '0;
            r_hit   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_count <= n_count;
                r_step  <= '0;
                r_hit   <= 1'b0;
            end else if (w_scan) begin
                r_step <= r_step + 1'b1;
                // cell 0 holds entry r_step of the sequence now
                if (!r_hit && (CW'(r_step) < r_count) && (w_cell_value[0] == r_key)) begin
                    r_hit <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_key <= i_req.value;
            r_pos <= '0;
        end else if (w_scan && !r_hit && (CW'(r_step) < r_count)
                     && (w_cell_value[0] == r_key)) begin
            r_pos <= r_step;
        end
    end

    assign w_pos_ext  = {{POS_W{1'b0}}, r_pos};
    assign w_cnt_ext  = {{COUNT_W{1'b0}}, r_count};
    assign w_ncnt_ext = {{COUNT_W{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fin_load) begin
            r_out_valid <= 1'b1;
        end else if (w_accept && (i_req.req_type != REQ_SEARCH)) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fin_load) begin
            r_out_status <= STS_DONE;
            r_out_found  <= r_hit;
            r_out_pos    <= r_hit ? w_pos_ext[POS_W-1:0] : '0;
            r_out_count  <= w_cnt_ext[COUNT_W-1:0];
        end else if (w_accept && (i_req.req_type != REQ_SEARCH)) begin
            r_out_status <= w_status;
            r_out_found  <= 1'b0;
            r_out_pos    <= '0;
            r_out_count  <= w_ncnt_ext[COUNT_W-1:0];
        end
    end

    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.status   = r_out_status;
    assign o_rsp.found    = r_out_found;
    assign o_rsp.position = r_out_pos;
    assign o_rsp.count    = r_out_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_scan_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) && w_last_step |=> (r_state == ST_FIN))
        else $error("scan did not finish after a full rotation");

    a_scan_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |=> $stable(r_count))
        else $error("count changed during search");

    a_hit_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hit && (r_state != ST_IDLE) |-> (CW'(r_pos) < r_count))
        else $error("match position beyond held entries");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !w_accept)
        else $error("request taken during search");

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

import bd_pkg::*;

typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [POS_W-1:0]    position;
    logic [COUNT_W-1:0]  count;
} t_deque_rsp;

// Shadow copy of the deque; predicts one response per request transfer.
class deque_tracker;
    logic [VALUE_W-1:0] ring [DEPTH_DEF];
    int unsigned        head;
    int unsigned        held;
    t_deque_rsp         awaited_rsp [$];
    int unsigned        errors;

    function void clear();
        head   = 0;
        held   = 0;
        errors = 0;
        awaited_rsp.delete();
    endfunction

    function void note_request(logic [REQ_W-1:0] kind, logic [VALUE_W-1:0] data);
        t_deque_rsp  r;
        int unsigned i;
        bit          hit;
        r        = '0;
        r.status = STS_DONE;
        hit      = 0;
        case (kind)
            REQ_INS_FRONT: begin
                if (held >= DEPTH_DEF) begin
                    r.status = STS_FULL;
                end else begin
                    head       = (head + DEPTH_DEF - 1) % DEPTH_DEF;
                    ring[head] = data;
                    held++;
                end
            end
            REQ_INS_BACK: begin
                if (held >= DEPTH_DEF) begin
                    r.status = STS_FULL;
                end else begin
                    ring[(head + held) % DEPTH_DEF] = data;
                    held++;
                end
            end
            REQ_DEL_FRONT: begin
                if (held == 0) begin
                    r.status = STS_EMPTY;
                end else begin
                    head = (head + 1) % DEPTH_DEF;
                    held--;
                end
            end
            REQ_DEL_BACK: begin
                if (held == 0) begin
                    r.status = STS_EMPTY;
                end else begin
                    held--;
                end
            end
            REQ_SEARCH: begin
                // first match from the front wins
                for (i = 0; i < held; i++) begin
                    if (!hit && ring[(head + i) % DEPTH_DEF] == data) begin
                        hit        = 1;
                        r.found    = 1'b1;
                        r.position = POS_W'(i);
                    end
                end
            end
            default: ;
        endcase
        r.count = COUNT_W'(held);
        awaited_rsp.push_back(r);
    endfunction

    function void check_response(t_deque_rsp got);
        t_deque_rsp want;
        if (awaited_rsp.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display({"%0t: response with none pending: ",
                          "status %0d found %0d pos %0d count %0d"},
                         $time, got.status, got.found, got.position, got.count);
            return;
        end
        want = awaited_rsp.pop_front();
        if (got.status !== want.status || got.found !== want.found ||
            got.position !== want.position || got.count !== want.count) begin
            errors++;
            if (errors <= 10)
                $display({"%0t: mismatch: status %0d/%0d found %0d/%0d ",
                          "pos %0d/%0d count %0d/%0d (exp/act)"},
                         $time, want.status, got.status, want.found, got.found,
                         want.position, got.position, want.count, got.count);
        end
    endfunction
endclass

module testbench;

    localparam int STALL_LIMIT = 2000;
    localparam int NUM_ITEMS   = 1450;

    logic clk;
    logic rst_n;
    bit   smooth;
    int   stalled;

    deque_tracker sb;

    bd_req_if req_ch ();
    bd_rsp_if rsp_ch ();

    bounded_deque_with_search_unit u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // mix of corner values and duplicates with fully random words
    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] pool [8];
        pool = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h0000_0001, 32'h0000_0002, 32'h0000_0003, 32'h0000_0004};
        if ($urandom_range(0, 9) < 4) return pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    task automatic push_request(input logic [REQ_W-1:0] kind, input logic [VALUE_W-1:0] data);
        int gap;
        bit took;
        gap = smooth ? 0 : pick_gap();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.value    <= data;
        do begin
            @(negedge clk);
            took = req_ch.ready;
            @(posedge clk);
        end while (!took);
    endtask

    task automatic directed_checks();
        int                 k;
        logic [VALUE_W-1:0] tail_val;
        tail_val = '0;
        push_request(REQ_DEL_FRONT, 32'h1234_5678);
        push_request(REQ_DEL_BACK, 32'hFFFF_FFFF);
        push_request(REQ_SEARCH, 32'h0000_0000);
        push_request(3'd5, 32'h0);
        push_request(3'd6, 32'hFFFF_FFFF);
        push_request(3'd7, 32'h0);
        push_request(REQ_INS_BACK, 32'h7FFF_FFFF);
        push_request(REQ_INS_FRONT, 32'h8000_0000);
        for (k = 0; k < DEPTH_DEF - 2; k++) begin
            tail_val = (k == 5) ? 32'h7FFF_FFFF : $urandom;
            push_request(k[0] ? REQ_INS_BACK : REQ_INS_FRONT, tail_val);
        end
        push_request(REQ_INS_FRONT, 32'hDEAD_BEEF);
        push_request(REQ_INS_BACK, 32'h0000_0000);
        push_request(REQ_SEARCH, 32'h8000_0000);
        push_request(REQ_SEARCH, 32'h7FFF_FFFF);
        push_request(REQ_SEARCH, tail_val);
        push_request(REQ_DEL_BACK, 32'h0);
        push_request(REQ_DEL_FRONT, 32'h0);
    endtask

    task automatic random_traffic(input int unsigned n);
        int unsigned        done_items;
        logic [REQ_W-1:0]   kind;
        logic [VALUE_W-1:0] data;
        bit                 grow;
        int                 r;
        grow       = 1;
        done_items = 0;
        while (done_items < n) begin
            if (done_items % 150 == 0) smooth = ($urandom_range(0, 3) == 0);
            // drift between filling and draining so both boundaries get hit
            if (sb.held == DEPTH_DEF && $urandom_range(0, 2) == 0) grow = 0;
            if (sb.held == 0 && $urandom_range(0, 2) == 0) grow = 1;
            if ($urandom_range(0, 39) == 0) grow = !grow;
            r = $urandom_range(0, 99);
            if (r < 3) begin
                kind = REQ_W'($urandom_range(5, 7));
                data = $urandom;
            end else if (r < 30) begin
                kind = REQ_SEARCH;
                if (sb.held > 0 && $urandom_range(0, 1) == 1)
                    data = sb.ring[(sb.head + $urandom_range(0, sb.held - 1)) % DEPTH_DEF];
                else
                    data = pick_value();
            end else if ($urandom_range(0, 99) < (grow ? 75 : 25)) begin
                kind = $urandom_range(0, 1) ? REQ_INS_BACK : REQ_INS_FRONT;
                data = pick_value();
            end else begin
                kind = $urandom_range(0, 1) ? REQ_DEL_BACK : REQ_DEL_FRONT;
                data = $urandom;
            end
            push_request(kind, data);
            if (kind <= REQ_SEARCH) done_items++;
        end
        smooth = 0;
    endtask

    // sink side: alternate open windows and stalls
    initial begin
        int   hold;
        logic level;
        rsp_ch.ready <= 1'b0;
        hold  = 0;
        level = 1'b0;
        forever begin
            @(posedge clk);
            if (hold == 0) begin
                level = !level;
                hold  = level ? $urandom_range(1, 12) : (smooth ? 0 : pick_gap());
                if (hold == 0) begin
                    level = 1'b1;
                    hold  = $urandom_range(1, 12);
                end
            end
            rsp_ch.ready <= level;
            hold--;
        end
    end

    // sample both channels mid-cycle; a transfer completes at the next rising edge
    always @(negedge clk) begin
        t_deque_rsp got;
        bit         moved;
        if (rst_n) begin
            moved = 0;
            if (req_ch.valid && req_ch.ready) begin
                sb.note_request(req_ch.req_type, req_ch.value);
                moved = 1;
            end
            if (rsp_ch.valid && rsp_ch.ready) begin
                got.status   = rsp_ch.status;
                got.found    = rsp_ch.found;
                got.position = rsp_ch.position;
                got.count    = rsp_ch.count;
                sb.check_response(got);
                moved = 1;
            end
            if (moved) stalled = 0;
            else stalled++;
            if (stalled >= STALL_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        sb = new;
        sb.clear();
        smooth  = 0;
        stalled = 0;
        rst_n           <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.req_type <= REQ_SEARCH;
        req_ch.value    <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_checks();
        random_traffic(NUM_ITEMS);
        req_ch.valid <= 1'b0;
        while (sb.awaited_rsp.size() != 0) @(posedge clk);
        repeat (DEPTH_DEF + 4) @(posedge clk);
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
